FILE: hdl/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache model.
// Used by salc_ctrl, salc_dpath and set_assoc_lru_cache_model_unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int WAYS_DEF         = 8;
  localparam int ADDR_WIDTH_DEF   = 48;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam int OPCODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_IFETCH = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [3:0] WAYS_USED_RST   = 4'd1;
  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clr_step;
  } salc_cmd_t;

  typedef struct packed {
    logic in_fetch;
    logic out_busy;
    logic clr_last;
  } salc_stat_t;

endpackage

`default_nettype wire

FILE: hdl/salc_ctrl.sv
// Controller state machine of the cache model: reset clearing sweep,
// request acceptance and lookup sequencing. Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  salc_pkg::salc_stat_t stat,
  output salc_pkg::salc_cmd_t  cmd
);
  import salc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.commit   = 1'b0;
    cmd.clr_step = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !stat.in_fetch) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.in_fetch) |=> (state_r == ST_LOOK))
    else $error("accepted request did not enter lookup");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!stat.out_busy && !in_ready))
    else $error("commit while result register is held");

endmodule

`default_nettype wire

FILE: hdl/salc_dpath.sv
// Datapath of the cache model: configuration registers, address split, set
// memory, tag compare and LRU update, counters and result register.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salc_dpath #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire  [salc_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire  [ADDR_WIDTH-1:0]            in_address,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic                             out_was_hit,
  output logic                             out_was_miss,
  output logic                             out_was_eviction,
  output logic [1:0]                       out_hits_added,
  output logic [COUNT_WIDTH-1:0]           out_hit_total,
  output logic [COUNT_WIDTH-1:0]           out_miss_total,
  output logic [COUNT_WIDTH-1:0]           out_eviction_total,
  input  salc_pkg::salc_cmd_t              cmd,
  output salc_pkg::salc_stat_t             stat
);
  import salc_pkg::*;

  localparam int NSETS  = 1 << MAX_SET_BITS;
  localparam int SIDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WI_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * (1 + RW + ADDR_WIDTH);
  localparam logic [RW-1:0] RMAX = RW'(WAYS - 1);

  logic [2:0] cfg_sb_r;
  logic [3:0] cfg_ways_r;
  logic [4:0] cfg_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sb_r   <= SET_BITS_RST;
      cfg_ways_r <= WAYS_USED_RST;
      cfg_off_r  <= OFFSET_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    cfg_sb_r   <= cfg_wdata[2:0];
        CFG_WAYS_USED:   cfg_ways_r <= cfg_wdata[3:0];
        CFG_OFFSET_BITS: cfg_off_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Address split.
  logic [3:0]            sb_eff;
  logic [5:0]            tag_sh;
  logic [SIDX_W-1:0]     set_mask;
  logic [SIDX_W-1:0]     rd_idx;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic [ADDR_WIDTH-1:0] off_addr;

  always_comb begin
    sb_eff   = (32'(cfg_sb_r) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, cfg_sb_r};
    tag_sh   = 6'(cfg_off_r) + 6'(sb_eff);
    set_mask = ~({SIDX_W{1'b1}} << sb_eff);
    off_addr = in_address >> cfg_off_r;
    rd_idx   = off_addr[SIDX_W-1:0] & set_mask;
    in_tag   = in_address >> tag_sh;
  end

  logic [SIDX_W-1:0]     set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic                  mod_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r <= rd_idx;
      tag_r <= in_tag;
      mod_r <= (in_opcode == OP_MODIFY);
    end
  end

  // Set memory and reset clearing sweep.
  logic [ROW_W-1:0]  mem [NSETS];
  logic [ROW_W-1:0]  rd_row_r;
  logic [ROW_W-1:0]  new_row;
  logic [SIDX_W-1:0] clr_cnt_r;
  logic              mem_we;
  logic [SIDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign mem_we    = cmd.clr_step | cmd.commit;
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : set_r;
  assign mem_wdata = cmd.clr_step ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_row_r <= mem[rd_idx];
    end
  end

  // Lookup and replacement.
  logic [WAYS-1:0]                 rv, nv, use_m;
  logic [WAYS-1:0][RW-1:0]         rr, nr;
  logic [WAYS-1:0][ADDR_WIDTH-1:0] rt, nt;
  logic            lk_hit, lk_empty, lk_vfound, lk_evict, age_all;
  logic [WI_W-1:0] hit_way, empty_way, victim, target;
  logic [RW-1:0]   best, limit;

  assign {rv, rr, rt} = rd_row_r;
  assign new_row      = {nv, nr, nt};

  always_comb begin
    lk_hit    = 1'b0;
    lk_empty  = 1'b0;
    lk_vfound = 1'b0;
    hit_way   = '0;
    empty_way = '0;
    victim    = '0;
    best      = '0;
    for (int i = 0; i < WAYS; i++) begin
      use_m[i] = (i == 0) || (32'(cfg_ways_r) > i);
    end
    for (int i = 0; i < WAYS; i++) begin
      if (use_m[i] && rv[i] && (rt[i] == tag_r) && !lk_hit) begin
        lk_hit  = 1'b1;
        hit_way = WI_W'(i);
      end
      if (use_m[i] && !rv[i] && !lk_empty) begin
        lk_empty  = 1'b1;
        empty_way = WI_W'(i);
      end
      if (use_m[i] && (!lk_vfound || (rr[i] > best))) begin
        lk_vfound = 1'b1;
        best      = rr[i];
        victim    = WI_W'(i);
      end
    end
    lk_evict = !lk_hit && !lk_empty;
    age_all  = !lk_hit && lk_empty;
    target   = lk_hit ? hit_way : (lk_empty ? empty_way : victim);
    limit    = lk_hit ? rr[hit_way] : best;
    nv = rv;
    nt = rt;
    for (int i = 0; i < WAYS; i++) begin
      if (WI_W'(i) == target) begin
        nr[i] = '0;
      end else if (use_m[i] && rv[i] && (age_all || (rr[i] < limit)) && (rr[i] < RMAX)) begin
        nr[i] = rr[i] + 1'b1;
      end else begin
        nr[i] = rr[i];
      end
    end
    if (!lk_hit) begin
      nv[target] = 1'b1;
      nt[target] = tag_r;
    end
  end

  // Counters and result register.
  logic [COUNT_WIDTH-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [1:0]             added;
  logic                   out_valid_r;

  assign added = {1'b0, lk_hit} + {1'b0, mod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        hit_cnt_r   <= hit_cnt_r + COUNT_WIDTH'(added);
        miss_cnt_r  <= miss_cnt_r + COUNT_WIDTH'(!lk_hit);
        evict_cnt_r <= evict_cnt_r + COUNT_WIDTH'(lk_evict);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_was_hit      <= lk_hit;
      out_was_miss     <= !lk_hit;
      out_was_eviction <= lk_evict;
      out_hits_added   <= added;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

  assign stat.in_fetch = (in_opcode == OP_IFETCH);
  assign stat.out_busy = out_valid_r & ~out_ready;
  assign stat.clr_last = (clr_cnt_r == SIDX_W'(NSETS - 1));

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_hit_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !lk_hit && !mod_r) |=> $stable(hit_cnt_r))
    else $error("hit count moved on a plain miss");

  a_miss_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !lk_hit) |=> (miss_cnt_r == $past(miss_cnt_r) + 1'b1))
    else $error("miss count did not advance on a miss");

endmodule

`default_nettype wire

FILE: hdl/set_assoc_lru_cache_model_unit.sv
// Top level of the set-associative LRU cache model.
// Instantiates salc_ctrl and salc_dpath; depends on salc_pkg.
//
// Each request carries an opcode and a byte address on a valid/ready
// channel; each load, store or modify returns one result on the out_
// channel with hit, miss and eviction flags and the running counters.
// Instruction fetch requests are accepted and give no result.
// The configuration port writes one of set_bits, ways_used and offset_bits
// at a time, as cfg_index selects; write it only while no request is in flight.
// The set row is read from the set memory into a register in the accept
// cycle; tag compare, LRU update and write-back of the row follow in
// ST_LOOK, and the result is registered into out_valid as the row is
// written back. No new request is taken until the row is written back,
// set by the read then write of the single set memory row. A new request
// is taken while a result still waits; if the receiver stalls, the next
// lookup holds until the result register is free.
// After reset, a clearing pass writes every row of the set memory,
// 2**MAX_SET_BITS rows (64 by default), one row a cycle, with in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model_unit #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [salc_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire  [ADDR_WIDTH-1:0]            in_address,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_was_hit,
  output logic                             out_was_miss,
  output logic                             out_was_eviction,
  output logic [1:0]                       out_hits_added,
  output logic [COUNT_WIDTH-1:0]           out_hit_total,
  output logic [COUNT_WIDTH-1:0]           out_miss_total,
  output logic [COUNT_WIDTH-1:0]           out_eviction_total
);
  import salc_pkg::*;

  salc_cmd_t  cmd;
  salc_stat_t stat;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  salc_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_opcode),
    .in_address         (in_address),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_was_hit        (out_was_hit),
    .out_was_miss       (out_was_miss),
    .out_was_eviction   (out_was_eviction),
    .out_hits_added     (out_hits_added),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

`default_nettype wire

FILE: test/set_assoc_lru_cache_model_unit_tb.sv
// Self-checking testbench for set_assoc_lru_cache_model_unit: a scoreboard class
// predicts hit, miss, eviction and counter values per result under random handshakes.
// Depends on salc_pkg and the set_assoc_lru_cache_model_unit RTL.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_unit_tb;
  import salc_pkg::*;

  localparam int AW           = ADDR_WIDTH_DEF;
  localparam int CW           = COUNT_WIDTH_DEF;
  localparam int LINES        = (1 << MAX_SET_BITS_DEF) * WAYS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic          hit;
    logic          miss;
    logic          evict;
    logic [1:0]    added;
    logic [CW-1:0] hits;
    logic [CW-1:0] misses;
    logic [CW-1:0] evicts;
  } cache_result_t;

  class cache_scoreboard;
    bit            line_valid [LINES];
    logic [AW-1:0] line_tag   [LINES];
    int            line_rank  [LINES];
    logic [CW-1:0] hit_tally;
    logic [CW-1:0] miss_tally;
    logic [CW-1:0] evict_count;
    logic [2:0]    set_bits_q;
    logic [3:0]    ways_q;
    logic [4:0]    offset_q;
    cache_result_t expected_q[$];
    int            fail_count;

    function new();
      for (int k = 0; k < LINES; k++) begin
        line_valid[k] = 1'b0;
        line_tag[k]   = '0;
        line_rank[k]  = 0;
      end
      hit_tally   = '0;
      miss_tally  = '0;
      evict_count = '0;
      set_bits_q  = SET_BITS_RST;
      ways_q      = WAYS_USED_RST;
      offset_q    = OFFSET_BITS_RST;
      fail_count  = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SET_BITS: begin
          set_bits_q = value[2:0];
        end
        CFG_WAYS_USED: begin
          ways_q = value[3:0];
        end
        CFG_OFFSET_BITS: begin
          offset_q = value[4:0];
        end
        default: begin
        end
      endcase
    endfunction

    // The target way becomes most recent; valid ways ranked below the limit age by one.
    function void promote(int base, int nways, int target, int limit);
      for (int i = 0; i < nways; i++) begin
        if (i != target && line_valid[base + i] && line_rank[base + i] < limit &&
            line_rank[base + i] < WAYS_DEF - 1) begin
          line_rank[base + i]++;
        end
      end
      line_rank[base + target] = 0;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [AW-1:0] addr);
      int            eff_sb;
      int            nways;
      int            off;
      int            base;
      int            found_way;
      int            free_way;
      int            victim;
      int            top_rank;
      logic [AW-1:0] tag;
      cache_result_t r;
      if (op == OP_IFETCH) return;
      eff_sb = (set_bits_q > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(set_bits_q);
      nways  = (ways_q == 0) ? 1 : (ways_q > WAYS_DEF) ? WAYS_DEF : int'(ways_q);
      off    = int'(offset_q);
      base   = int'((addr >> off) & ((48'd1 << eff_sb) - 48'd1)) * WAYS_DEF;
      tag    = addr >> (off + eff_sb);
      r      = '0;
      found_way = -1;
      for (int i = 0; i < nways; i++) begin
        if (found_way < 0 && line_valid[base + i] && line_tag[base + i] == tag) found_way = i;
      end
      if (found_way >= 0) begin
        promote(base, nways, found_way, line_rank[base + found_way]);
        hit_tally = hit_tally + 1'b1;
        r.hit     = 1'b1;
        r.added   = 2'd1;
      end else begin
        miss_tally = miss_tally + 1'b1;
        r.miss     = 1'b1;
        free_way   = -1;
        for (int i = 0; i < nways; i++) begin
          if (free_way < 0 && !line_valid[base + i]) free_way = i;
        end
        if (free_way >= 0) begin
          promote(base, nways, free_way, WAYS_DEF + 1);
          line_tag[base + free_way]   = tag;
          line_valid[base + free_way] = 1'b1;
        end else begin
          // Oldest valid way goes; ties resolve to the lowest way number.
          victim   = 0;
          top_rank = -1;
          for (int i = 0; i < nways; i++) begin
            if (line_rank[base + i] > top_rank) begin
              top_rank = line_rank[base + i];
              victim   = i;
            end
          end
          r.evict     = 1'b1;
          evict_count = evict_count + 1'b1;
          promote(base, nways, victim, top_rank);
          line_tag[base + victim] = tag;
        end
      end
      if (op == OP_MODIFY) begin
        hit_tally = hit_tally + 1'b1;
        r.added   = r.added + 2'd1;
      end
      r.hits   = hit_tally;
      r.misses = miss_tally;
      r.evicts = evict_count;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      check_field("was_hit", 64'(want.hit), 64'(got.hit));
      check_field("was_miss", 64'(want.miss), 64'(got.miss));
      check_field("was_eviction", 64'(want.evict), 64'(got.evict));
      check_field("hits_added", 64'(want.added), 64'(got.added));
      check_field("hit_total", 64'(want.hits), 64'(got.hits));
      check_field("miss_total", 64'(want.misses), 64'(got.misses));
      check_field("eviction_total", 64'(want.evicts), 64'(got.evicts));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode  = OP_LOAD;
  logic [AW-1:0]         in_address = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  out_was_hit;
  logic                  out_was_miss;
  logic                  out_was_eviction;
  logic [1:0]            out_hits_added;
  logic [CW-1:0]         out_hit_total;
  logic [CW-1:0]         out_miss_total;
  logic [CW-1:0]         out_eviction_total;

  cache_scoreboard board;
  int              cycle_count = 0;
  int              burst_left  = 0;
  logic [7:0]      ready_bits  = 8'hFF;
  logic [2:0]      ready_step  = '0;
  logic [AW-1:0]   tag_pool [16];
  int              set_pool [3];
  int              tag_pool_n;

  set_assoc_lru_cache_model_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_hit       (out_was_hit),
    .out_was_miss      (out_was_miss),
    .out_was_eviction  (out_was_eviction),
    .out_hits_added    (out_hits_added),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .out_eviction_total(out_eviction_total)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("set_assoc_lru_cache_model_unit regression: fail");
      $finish;
    end
  end

  // Result side: checks each accepted result and stalls on a random 8-bit ready pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result({out_was_hit, out_was_miss, out_was_eviction, out_hits_added,
                          out_hit_total, out_miss_total, out_eviction_total});
    end
    if (ready_step == 3'd0) begin
      case ($urandom_range(0, 4))
        0, 1: ready_bits = 8'hFF;
        2: ready_bits = 8'h00;
        default: ready_bits = 8'($urandom);
      endcase
    end
    out_ready <= ready_bits[ready_step];
    ready_step = ready_step + 3'd1;
  end

  task automatic send_req(logic [OPCODE_W-1:0] op, logic [AW-1:0] addr);
    int gap_len;
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(op, addr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  // Requests that give no result may still be in flight, so a short settle follows.
  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] ways,
                              logic [CFG_DATA_W-1:0] off);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= sb;
    @(posedge clk);
    board.set_config(CFG_SET_BITS, sb);
    cfg_index <= CFG_WAYS_USED;
    cfg_wdata <= ways;
    @(posedge clk);
    board.set_config(CFG_WAYS_USED, ways);
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    board.set_config(CFG_OFFSET_BITS, off);
    cfg_we <= 1'b0;
  endtask

  // Mostly addresses from a small tag and set pool so that sets fill, hit and evict.
  function automatic logic [AW-1:0] pick_address(int eff_sb, int off);
    logic [63:0] addr;
    logic [63:0] low;
    if ($urandom_range(0, 6) == 0) begin
      addr = {$urandom, $urandom};
    end else begin
      low  = {$urandom, $urandom} & ((64'd1 << off) - 64'd1);
      addr = ({16'd0, tag_pool[$urandom_range(0, tag_pool_n - 1)]} << (off + eff_sb)) |
             (64'(set_pool[$urandom_range(0, 2)]) << off) | low;
    end
    return addr[AW-1:0];
  endfunction

  task automatic run_phase(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] ways,
                           logic [CFG_DATA_W-1:0] off, int count);
    int            eff_sb;
    int            nways;
    int            done;
    logic [OPCODE_W-1:0] op;
    wait_drained();
    write_config(sb, ways, off);
    eff_sb     = (sb[2:0] > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(sb[2:0]);
    nways      = (ways[3:0] == 0) ? 1 : (ways[3:0] > WAYS_DEF) ? WAYS_DEF : int'(ways[3:0]);
    tag_pool_n = nways + $urandom_range(0, 3);
    for (int i = 0; i < tag_pool_n; i++) tag_pool[i] = AW'({$urandom, $urandom});
    for (int i = 0; i < 3; i++) set_pool[i] = $urandom_range(0, (1 << eff_sb) - 1);
    done = 0;
    while (done < count) begin
      op = OPCODE_W'($urandom_range(0, 3));
      send_req(op, pick_address(eff_sb, int'(off)));
      done++;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Reset configuration: 16 sets, one way, 16-byte blocks.
    send_req(OP_LOAD, 48'h0000_0000_0000);
    send_req(OP_LOAD, 48'h0000_0000_0000);
    send_req(OP_STORE, 48'h0000_0000_0008);
    send_req(OP_MODIFY, 48'h0000_0000_0000);
    send_req(OP_IFETCH, 48'h0000_0000_0000);
    send_req(OP_LOAD, 48'h0000_0000_0100);
    send_req(OP_MODIFY, 48'h0000_0000_0200);
    send_req(OP_STORE, 48'hFFFF_FFFF_FFFF);
    send_req(OP_LOAD, 48'hFFFF_FFFF_FFFF);
    send_req(OP_IFETCH, 48'hFFFF_FFFF_FFFF);
    send_req(OP_LOAD, 48'h0000_0000_00F0);
    send_req(OP_MODIFY, 48'h0000_0000_00F5);
    send_req(OP_STORE, 48'h8000_0000_0000);
    send_req(OP_LOAD, 48'h5555_5555_5555);
    send_req(OP_LOAD, 48'hAAAA_AAAA_AAAA);
    send_req(OP_MODIFY, 48'hAAAA_AAAA_AAAA);
    in_valid <= 1'b0;

    run_phase(5'd0, 5'd1, 5'd0, 120);
    run_phase(5'd6, 5'd8, 5'd16, 200);
    run_phase(5'd7, 5'd15, 5'd31, 150);
    run_phase(5'd3, 5'd0, 5'd5, 120);
    run_phase(5'd2, 5'd4, 5'd2, 150);
    run_phase(5'd6, 5'd2, 5'd0, 120);
    run_phase(5'd1, 5'd8, 5'd12, 150);
    run_phase(5'd4, 5'd3, 5'd16, 150);
    run_phase(5'd5, 5'd6, 5'd7, 150);
    run_phase(5'd0, 5'd8, 5'd9, 150);
    wait_drained();

    if (board.fail_count == 0) begin
      $display("set_assoc_lru_cache_model_unit regression: pass");
    end else begin
      $display("set_assoc_lru_cache_model_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/salc_pkg.sv
hdl/salc_ctrl.sv
hdl/salc_dpath.sv
hdl/set_assoc_lru_cache_model_unit.sv
test/set_assoc_lru_cache_model_unit_tb.sv
